/* rtl/swhc_pkg.sv */
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared types and constants for the sliding window health check.
// ----------------------------------------------------------------------------
package swhc_pkg;

    // fixed field widths
    localparam int LAT_W      = 32;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 7;
    localparam int HIST_OUT_W = 64;

    // defaults for the top level parameters
    localparam int DEF_HISTORY_LEN = 64;
    localparam int DEF_MAX_RATE    = 4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_WINDOW_SIZE    = 7'd8;
    localparam logic [CFG_W-1:0] RST_PASS_THRESHOLD = 7'd3;

    // counting unit takes this many history bits per cycle
    localparam int CHUNK_W = 8;

    // configuration register indexes
    typedef enum logic {
        REG_WINDOW_SIZE    = 1'b0,
        REG_PASS_THRESHOLD = 1'b1
    } t_cfg_reg;

    // health transition codes
    typedef enum logic [1:0] {
        TR_STILL_HEALTHY = 2'd0,
        TR_BACK_HEALTHY  = 2'd1,
        TR_WENT_SICK     = 2'd2,
        TR_STILL_SICK    = 2'd3
    } t_transition;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

/* rtl/swhc_if.sv */
// ----------------------------------------------------------------------------
// swhc_if
// Valid/ready channels of the health check: probe words, result words and
// configuration writes.
// ----------------------------------------------------------------------------

// probe word channel
interface swhc_in_if;
    import swhc_pkg::*;
    logic             valid;
    logic             ready;
    logic             probe_passed;
    logic [LAT_W-1:0] latency_us;

    modport source (output valid, probe_passed, latency_us, input ready);
    modport sink   (input valid, probe_passed, latency_us, output ready);
endinterface

// result word channel
interface swhc_out_if;
    import swhc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  is_healthy;
    logic [1:0]            transition;
    logic [CNT_W-1:0]      pass_count;
    logic [LAT_W-1:0]      average_latency_us;
    logic [HIST_OUT_W-1:0] pass_history;

    modport source (output valid, is_healthy, transition, pass_count,
                    average_latency_us, pass_history, input ready);
    modport sink   (input valid, is_healthy, transition, pass_count,
                    average_latency_us, pass_history, output ready);
endinterface

// configuration write channel
interface swhc_cfg_if;
    import swhc_pkg::*;
    logic             valid;
    logic             ready;
    logic             index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/swhc_div.sv */
// ----------------------------------------------------------------------------
// swhc_div
// Iterative restoring divider, one quotient bit per cycle. Divides the
// latency difference magnitude by the small rate counter.
// ----------------------------------------------------------------------------
module swhc_div #(
    parameter int DIVISOR_W = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [swhc_pkg::LAT_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]       i_divisor,
    output logic [swhc_pkg::LAT_W-1:0] o_quotient,
    output logic                       o_busy
);
    import swhc_pkg::*;

    localparam int STEP_W = $clog2(LAT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LAT_W - 1);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic [LAT_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic [DIVISOR_W-1:0] n_rem;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[LAT_W-1]};
        fits  = trial >= {1'b0, r_div};
        if (fits) begin
            n_rem = DIVISOR_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIVISOR_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[LAT_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

    // start always launches a run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    // run ends after the last quotient bit
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_step == LAST_STEP |=> !r_busy)
        else $error("divider overran its step count");

    // partial remainder stays below a nonzero divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_div != '0 |-> r_rem < r_div)
        else $error("divider remainder out of range");

endmodule

/* rtl/swhc_popcnt.sv */
// ----------------------------------------------------------------------------
// swhc_popcnt
// Counts the set bits among the newest window entries of the history,
// one byte of history per cycle.
// ----------------------------------------------------------------------------
module swhc_popcnt #(
    parameter int HISTORY_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [HISTORY_LEN-1:0]     i_history,
    input  logic [swhc_pkg::CFG_W-1:0] i_window,
    output logic [swhc_pkg::CNT_W-1:0] o_count,
    output logic                       o_busy
);
    import swhc_pkg::*;

    localparam int NCHUNK = (HISTORY_LEN + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCHUNK - 1);

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [PAD_W-1:0]   r_hist;
    logic [CFG_W-1:0]   r_win;
    logic [CNT_W-1:0]   r_base;
    logic [CNT_W-1:0]   r_count;

    logic [CNT_W-1:0]   chunk_sum;

    // masked count of the low byte of the shifting history
    always_comb begin
        chunk_sum = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (r_hist[j] && ((r_base + CNT_W'(j)) < r_win)) begin
                chunk_sum = chunk_sum + 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hist  <= PAD_W'(i_history);
            r_win   <= i_window;
            r_base  <= '0;
            r_count <= '0;
        end else if (r_busy) begin
            r_hist  <= r_hist >> CHUNK_W;
            r_base  <= r_base + CNT_W'(CHUNK_W);
            r_count <= r_count + chunk_sum;
        end
    end

    assign o_count = r_count;
    assign o_busy  = r_busy;

    // start always launches a run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("counter did not start");

    // count never exceeds the bits already scanned
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_count <= r_base)
        else $error("pass count exceeds scanned bits");

    // run ends after the last byte
    a_last_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_idx == LAST_IDX |=> !r_busy)
        else $error("counter overran its byte count");

endmodule

/* rtl/sliding_window_health_check.sv */
// ----------------------------------------------------------------------------
// sliding_window_health_check
// K-of-N sliding window health check with a running latency average.
// ----------------------------------------------------------------------------
// Each probe word is taken only while the block is idle. The block then
// waits for the one-bit-per-cycle divider that moves the latency average
// and loads the result word into the output register once that register
// is free. The pass count runs alongside on a one-byte-per-cycle counter
// and finishes earlier. A new probe word may be taken while the previous
// result still waits in the output register. Configuration writes are
// always ready and must only be issued while no probe is in flight.
module sliding_window_health_check #(
    parameter int HISTORY_LEN = swhc_pkg::DEF_HISTORY_LEN,
    parameter int MAX_RATE    = swhc_pkg::DEF_MAX_RATE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swhc_in_if.sink     i_in,
    swhc_out_if.source  o_res,
    swhc_cfg_if.sink    i_cfg
);
    import swhc_pkg::*;

    localparam int RATE_W = $clog2(MAX_RATE + 1);
    localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(MAX_RATE);

    // configuration registers
    logic [CFG_W-1:0] r_window_size;
    logic [CFG_W-1:0] r_pass_threshold;

    // block state
    t_state                 r_state;
    t_state                 n_state;
    logic [HISTORY_LEN-1:0] r_hist;
    logic [RATE_W-1:0]      r_rate;
    logic [RATE_W-1:0]      n_rate;
    logic [LAT_W-1:0]       r_avg;
    logic [LAT_W-1:0]       n_avg;
    logic                   r_healthy;
    logic                   r_passed;
    logic                   r_neg;

    // output register
    logic                   r_out_valid;
    logic                   r_o_healthy;
    t_transition            r_o_trans;
    logic [CNT_W-1:0]       r_o_count;
    logic [LAT_W-1:0]       r_o_avg;
    logic [HIST_OUT_W-1:0]  r_o_hist;

    // sequencer outputs and unit links
    logic                   in_ready;
    logic                   accept;
    logic                   load;
    logic                   lat_ge;
    logic [LAT_W-1:0]       diff_mag;
    logic [HISTORY_LEN-1:0] n_hist;
    logic [LAT_W-1:0]       quotient;
    logic                   div_busy;
    logic [CNT_W-1:0]       count;
    logic                   cnt_busy;
    logic                   now_healthy;
    t_transition            trans;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size    <= RST_WINDOW_SIZE;
            r_pass_threshold <= RST_PASS_THRESHOLD;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_WINDOW_SIZE:    r_window_size    <= i_cfg.data;
                REG_PASS_THRESHOLD: r_pass_threshold <= i_cfg.data;
                default:            ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_RUN;
            ST_RUN:  if (!div_busy && !cnt_busy) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || o_res.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        load     = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  ;
            ST_DONE: load = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    assign i_in.ready = in_ready;
    assign accept     = in_ready && i_in.valid;

    // history shift and rate update for the incoming word
    assign n_hist = {r_hist[HISTORY_LEN-2:0], i_in.probe_passed};
    assign n_rate = (i_in.probe_passed && r_rate < RATE_MAX) ? r_rate + 1'b1 : r_rate;

    // magnitude and sign of latency minus average
    assign lat_ge   = i_in.latency_us >= r_avg;
    assign diff_mag = lat_ge ? i_in.latency_us - r_avg : r_avg - i_in.latency_us;

    // divider and pass counter units
    swhc_div #(
        .DIVISOR_W (RATE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (diff_mag),
        .i_divisor  (n_rate),
        .o_quotient (quotient),
        .o_busy     (div_busy)
    );

    swhc_popcnt #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_popcnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_history (n_hist),
        .i_window  (r_window_size),
        .o_count   (count),
        .o_busy    (cnt_busy)
    );

    // final result arithmetic
    always_comb begin
        n_avg       = r_neg ? r_avg - quotient : r_avg + quotient;
        now_healthy = count >= r_pass_threshold;
        if (now_healthy) begin
            trans = r_healthy ? TR_STILL_HEALTHY : TR_BACK_HEALTHY;
        end else begin
            trans = r_healthy ? TR_WENT_SICK : TR_STILL_SICK;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hist      <= '0;
            r_rate      <= '0;
            r_avg       <= '0;
            r_healthy   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_hist <= n_hist;
                r_rate <= n_rate;
            end
            if (load) begin
                r_healthy <= now_healthy;
                if (r_passed) begin
                    r_avg <= n_avg;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_passed <= i_in.probe_passed;
            r_neg    <= !lat_ge;
        end
        if (load) begin
            r_o_healthy <= now_healthy;
            r_o_trans   <= trans;
            r_o_count   <= count;
            r_o_avg     <= r_passed ? n_avg : r_avg;
            r_o_hist    <= HIST_OUT_W'(r_hist);
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.is_healthy         = r_o_healthy;
    assign o_res.transition         = r_o_trans;
    assign o_res.pass_count         = r_o_count;
    assign o_res.average_latency_us = r_o_avg;
    assign o_res.pass_history       = r_o_hist;

    // rate counter saturates
    a_rate_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rate <= RATE_MAX)
        else $error("rate counter above its limit");

    // a passing word always divides by a nonzero rate
    a_rate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_passed |-> r_rate != '0)
        else $error("average update with zero rate");

    // a taken word blocks further input until its result is loaded
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready && r_state == ST_RUN)
        else $error("input taken while a word is in flight");

    // units are idle whenever a result is loaded
    a_units_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !div_busy && !cnt_busy)
        else $error("result loaded before units finished");

endmodule
